@@ rtl/rtoa_pkg.sv @@
package rtoa_pkg;

	localparam int BASE_W = 5;
	localparam int NUM_W = 64;
	localparam int CHAR_W = 7;
	localparam int TOTAL_W = 7;
	localparam int SIGNED_W = 32;
	localparam int DIGIT_W = 4;

	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;
	localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

	localparam logic OP_UNSIGNED = 1'b0;
	localparam logic OP_SIGNED = 1'b1;

	typedef struct packed {
		logic op;
		logic [NUM_W-1:0] value;
		logic [BASE_W-1:0] base;
		logic uppercase;
	} conv_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ascii_digit;
		logic [TOTAL_W-1:0] digit_total;
		logic last;
	} conv_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} conv_state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
		input logic up);
		logic [CHAR_W-1:0] off;
		off = CHAR_W'(d - DIGIT_TEN);
		if (d < DIGIT_TEN) begin
			digit_char = CHAR_ZERO + CHAR_W'(d);
		end else if (up) begin
			digit_char = CHAR_UPPER_A + off;
		end else begin
			digit_char = CHAR_LOWER_A + off;
		end
	endfunction

endpackage

@@ rtl/rtoa_div.sv @@
module rtoa_div import rtoa_pkg::*; #(
	parameter int DW = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [DW-1:0] dividend,
	input  logic [BASE_W-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic [DIGIT_W-1:0] remainder,
	output logic done
);

	localparam int CW = $clog2(DW);

	logic [DW-1:0] quo_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [BASE_W-1:0] trial;
	logic [BASE_W-1:0] diff;
	logic fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits = trial >= divisor;
	assign diff = trial - divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;
	assign done = done_q;

endmodule

@@ rtl/radix_integer_to_ascii.sv @@
// channel | signals                  | transfer
// --------+--------------------------+---------------------------------
// input   | start, busy, item        | edge with start high, busy low
// result  | strobe, result           | every edge with strobe high
//
// each digit takes one pass of the shared one-bit-per-cycle divider, which is
// DW = max(VALUE_BITS, 32) bits wide; n digits are then read back from the digit
// store at one per cycle
// busy stays high from the transfer until the final digit has been shown
// reset clears the sequencer and counters; the digit store is not cleared
// results cannot be stalled: each digit is on the result port for one cycle
module radix_integer_to_ascii import rtoa_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  conv_in_t item,
	output logic strobe,
	output conv_out_t result
);

	localparam int DW = (VALUE_BITS > SIGNED_W) ? VALUE_BITS : SIGNED_W;
	localparam int AW = $clog2(DW);

	conv_state_t state_q;
	conv_state_t state_d;

	logic accept;
	logic go;
	logic wr_en;
	logic div_done;
	logic [DW-1:0] quotient;
	logic [DIGIT_W-1:0] remainder;
	logic [DW-1:0] dividend;
	logic [DW-1:0] load_val;
	logic [SIGNED_W-1:0] low_word;
	logic [SIGNED_W-1:0] magnitude;
	logic [BASE_W-1:0] base_sat;
	logic quot_zero;

	logic [BASE_W-1:0] base_q;
	logic upper_q;
	logic [TOTAL_W-1:0] cnt_q;
	logic [AW-1:0] ptr_q;
	logic [DIGIT_W-1:0] rdata_q;
	logic strb_s1;
	logic last_s1;

	logic [DIGIT_W-1:0] digit_mem [DW];

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE) || strb_s1;
	assign quot_zero = quotient == '0;

	assign low_word = item.value[SIGNED_W-1:0];
	assign magnitude = low_word[SIGNED_W-1] ? (~low_word + 1'b1) : low_word;
	assign load_val = (item.op == OP_SIGNED) ? DW'(magnitude)
		: DW'(item.value[VALUE_BITS-1:0]);

	always_comb begin
		base_sat = item.base;
		if (item.base < BASE_MIN) begin
			base_sat = BASE_MIN;
		end else if (item.base > BASE_MAX) begin
			base_sat = BASE_MAX;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done && quot_zero) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (ptr_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		go = 1'b0;
		wr_en = 1'b0;
		dividend = quotient;
		case (state_q)
			ST_IDLE: begin
				go = accept;
				dividend = load_val;
			end
			ST_DIV: begin
				wr_en = div_done;
				go = div_done && !quot_zero;
			end
			default: begin
				go = 1'b0;
			end
		endcase
	end

	rtoa_div #(
		.DW(DW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.dividend(dividend),
		.divisor(base_q),
		.quotient(quotient),
		.remainder(remainder),
		.done(div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			ptr_q <= '0;
			strb_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			strb_s1 <= state_q == ST_EMIT;
			last_s1 <= (state_q == ST_EMIT) && (ptr_q == '0);
			if (accept) begin
				cnt_q <= '0;
			end else if (wr_en) begin
				cnt_q <= cnt_q + 1'b1;
				if (quot_zero) begin
					ptr_q <= cnt_q[AW-1:0];
				end
			end else if (state_q == ST_EMIT) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= (item.op == OP_SIGNED) ? BASE_DEC : base_sat;
			upper_q <= item.uppercase;
		end
	end

	// digit store, least significant first
	always_ff @(posedge clk) begin
		if (wr_en) begin
			digit_mem[cnt_q[AW-1:0]] <= remainder;
		end
		rdata_q <= digit_mem[ptr_q];
	end

	assign strobe = strb_s1;
	assign result.ascii_digit = digit_char(rdata_q, upper_q);
	assign result.digit_total = cnt_q;
	assign result.last = last_s1;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after transfer");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !strobe)
		else $error("result after final digit");

	a_emit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |=> strobe)
		else $error("digit read without result strobe");

	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> cnt_q < TOTAL_W'(DW))
		else $error("digit store overflow");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> result.digit_total != '0)
		else $error("zero digit count on result");

endmodule

@@ verif/radix_integer_to_ascii_test.sv @@
`timescale 1ns / 1ps

module radix_integer_to_ascii_test;
	import rtoa_pkg::*;

	localparam int VALUE_BITS = 64;
	localparam logic [NUM_W-1:0] VALUE_MASK = {NUM_W{1'b1}} >> (NUM_W - VALUE_BITS);
	localparam int RANDOM_ITEMS = 330;
	localparam int STALL_LIMIT = 30000;
	localparam int TAIL_CYCLES = 200;
	localparam int ITEM_W = $bits(conv_in_t);

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	conv_in_t item;
	logic strobe;
	conv_out_t result;

	conv_out_t digits_due[$];
	string typed_text[$];
	conv_in_t plan_items[$];
	string plan_text[$];

	int errors = 0;
	int stall_cycles = 0;
	int items_taken = 0;
	int signed_taken = 0;
	int clamped_taken = 0;
	int digits_seen = 0;
	int longest = 0;

	radix_integer_to_ascii #(
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%s", msg);
		end
	endtask

	// digits of one conversion, most significant first
	task automatic spell_digits(input conv_in_t it);
		logic [NUM_W-1:0] rest;
		logic [NUM_W-1:0] radix;
		logic [SIGNED_W-1:0] low;
		logic [BASE_W-1:0] b;
		logic [DIGIT_W-1:0] d;
		logic [CHAR_W-1:0] ch;
		logic [CHAR_W-1:0] chars[$];
		conv_out_t r;
		if (it.op == OP_SIGNED) begin
			low = it.value[SIGNED_W-1:0];
			if (low[SIGNED_W-1]) begin
				low = -low;
			end
			rest = {{(NUM_W-SIGNED_W){1'b0}}, low};
			b = BASE_DEC;
		end else begin
			rest = it.value & VALUE_MASK;
			if (it.base < BASE_MIN) begin
				b = BASE_MIN;
			end else if (it.base > BASE_MAX) begin
				b = BASE_MAX;
			end else begin
				b = it.base;
			end
		end
		radix = NUM_W'(b);
		if (rest == '0) begin
			chars.push_front(CHAR_ZERO);
		end
		while (rest != '0) begin
			d = DIGIT_W'(rest % radix);
			ch = CHAR_W'(d);
			if (d < DIGIT_TEN) begin
				ch = CHAR_ZERO + ch;
			end else begin
				ch = (it.uppercase ? CHAR_UPPER_A : CHAR_LOWER_A) + ch - CHAR_W'(DIGIT_TEN);
			end
			chars.push_front(ch);
			rest = rest / radix;
		end
		for (int k = 0; k < chars.size(); k++) begin
			r.ascii_digit = chars[k];
			r.digit_total = TOTAL_W'(chars.size());
			r.last = (k == chars.size() - 1);
			digits_due.push_back(r);
		end
	endtask

	task automatic add_row(input logic op, input logic [NUM_W-1:0] value,
		input logic [BASE_W-1:0] base, input logic up, input string text);
		conv_in_t it;
		it.op = op;
		it.value = value;
		it.base = base;
		it.uppercase = up;
		plan_items.push_back(it);
		plan_text.push_back(text);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 4);
		end else if (r < 97) begin
			return $urandom_range(5, 30);
		end
		return $urandom_range(50, 2000);
	endfunction

	function automatic conv_in_t random_number();
		conv_in_t it;
		logic [NUM_W-1:0] raw;
		logic [SIGNED_W-1:0] low;
		raw = {$urandom, $urandom};
		it.op = ($urandom_range(0, 9) < 3) ? OP_SIGNED : OP_UNSIGNED;
		if (it.op == OP_SIGNED) begin
			case ($urandom_range(0, 5))
				0: low = SIGNED_W'($urandom_range(0, 1000));
				1: low = -SIGNED_W'($urandom_range(0, 1000));
				2: low = {1'b1, {(SIGNED_W-1){1'b0}}};
				3: low = raw[SIGNED_W-1:0] >> $urandom_range(0, 31);
				default: low = raw[SIGNED_W-1:0];
			endcase
			it.value = {raw[NUM_W-1:SIGNED_W], low};
		end else begin
			case ($urandom_range(0, 9))
				0: it.value = NUM_W'($urandom_range(0, 20));
				1, 2: it.value = raw;
				default: it.value = raw >> $urandom_range(0, 63);
			endcase
		end
		if ($urandom_range(0, 9) == 0) begin
			it.base = BASE_W'($urandom_range(0, 31));
		end else begin
			it.base = BASE_W'($urandom_range(2, 16));
		end
		it.uppercase = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// called just after a falling edge, returns at the falling edge after the transfer
	task automatic offer(input conv_in_t it);
		item <= it;
		start <= 1'b1;
		while (busy) begin
			@(negedge clk);
		end
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		conv_out_t want;
		string txt;
		byte c;
		if (arst_n) begin
			if (strobe) begin
				digits_seen++;
				if (digits_due.size() == 0) begin
					report($sformatf("unexpected digit %h total %0d last %b",
						result.ascii_digit, result.digit_total, result.last));
				end else begin
					want = digits_due.pop_front();
					if (want.digit_total > longest) begin
						longest = want.digit_total;
					end
					if (result.ascii_digit !== want.ascii_digit ||
						result.digit_total !== want.digit_total ||
						result.last !== want.last) begin
						report($sformatf("digit mismatch: expected %h/%0d/%b got %h/%0d/%b",
							want.ascii_digit, want.digit_total, want.last,
							result.ascii_digit, result.digit_total, result.last));
					end
				end
			end
			if (start && !busy) begin
				items_taken++;
				if (item.op == OP_SIGNED) begin
					signed_taken++;
				end else if (item.base < BASE_MIN || item.base > BASE_MAX) begin
					clamped_taken++;
				end
				txt = (typed_text.size() != 0) ? typed_text.pop_front() : "";
				if (txt.len() == 0) begin
					spell_digits(item);
				end else begin
					for (int k = 0; k < txt.len(); k++) begin
						c = txt[k];
						want.ascii_digit = c[CHAR_W-1:0];
						want.digit_total = TOTAL_W'(txt.len());
						want.last = (k == txt.len() - 1);
						digits_due.push_back(want);
					end
				end
			end
			if ((start && !busy) || strobe) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog: no transfer for %0d cycles, %0d digits pending",
			stall_cycles, digits_due.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [ITEM_W-1:0] junk;
		int gap;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;

		add_row(OP_UNSIGNED, 64'd0, 5'd10, 1'b0, "0");
		add_row(OP_SIGNED, 64'd0, 5'd0, 1'b1, "0");
		add_row(OP_UNSIGNED, '1, 5'd16, 1'b0, "ffffffffffffffff");
		add_row(OP_UNSIGNED, '1, 5'd16, 1'b1, "FFFFFFFFFFFFFFFF");
		add_row(OP_UNSIGNED, '1, 5'd10, 1'b0, "18446744073709551615");
		add_row(OP_UNSIGNED, '1, 5'd2, 1'b0, "");
		add_row(OP_UNSIGNED, 64'h0123456789ABCDEF, 5'd16, 1'b1, "123456789ABCDEF");
		add_row(OP_UNSIGNED, 64'hFEDCBA9876543210, 5'd16, 1'b0, "fedcba9876543210");
		add_row(OP_SIGNED, 64'hDEADBEEF_80000000, 5'd31, 1'b0, "2147483648");
		add_row(OP_SIGNED, 64'h00000000_7FFFFFFF, 5'd2, 1'b0, "2147483647");
		add_row(OP_SIGNED, 64'h00000000_80000001, 5'd16, 1'b1, "2147483647");
		add_row(OP_SIGNED, 64'hFFFFFFFF_FFFFFFFF, 5'd16, 1'b1, "1");
		add_row(OP_SIGNED, 64'hFFFFFFFF_00000000, 5'd10, 1'b0, "0");
		add_row(OP_SIGNED, 64'h12345678_FFFFFF85, 5'd10, 1'b0, "123");
		add_row(OP_UNSIGNED, 64'd5, 5'd0, 1'b0, "101");
		add_row(OP_UNSIGNED, 64'd5, 5'd1, 1'b0, "101");
		add_row(OP_UNSIGNED, 64'd255, 5'd17, 1'b0, "ff");
		add_row(OP_UNSIGNED, 64'd255, 5'd31, 1'b1, "FF");
		add_row(OP_UNSIGNED, 64'd1, 5'd2, 1'b0, "1");
		add_row(OP_UNSIGNED, 64'd10, 5'd10, 1'b0, "10");
		add_row(OP_UNSIGNED, 64'h8000000000000000, 5'd3, 1'b0, "");
		add_row(OP_UNSIGNED, 64'd1234567890, 5'd7, 1'b0, "");
		add_row(OP_UNSIGNED, 64'h0000000000ABCDEF, 5'd13, 1'b1, "");

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < plan_items.size() + RANDOM_ITEMS; i++) begin
			if (i < plan_items.size()) begin
				typed_text.push_back(plan_text[i]);
				offer(plan_items[i]);
			end else begin
				typed_text.push_back("");
				offer(random_number());
			end
			// hold off until the block has drained
			if (i == plan_items.size() - 1 || i == plan_items.size() + RANDOM_ITEMS / 2) begin
				start <= 1'b0;
				while (digits_due.size() != 0) begin
					@(negedge clk);
				end
				@(negedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					junk = ITEM_W'({$urandom, $urandom, $urandom});
					start <= 1'b0;
					item <= junk;
					repeat (gap) @(negedge clk);
				end
			end
		end
		start <= 1'b0;

		while (digits_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("converted %0d numbers (%0d signed, %0d with base out of range)",
			items_taken, signed_taken, clamped_taken);
		$display("checked %0d digits, longest conversion %0d digits, %0d failures",
			digits_seen, longest, errors);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
